// ===== sv/mfbde_pkg.sv =====
// mfbde_pkg.sv: constants, codes and types of the one-bit framebuffer draw engine
`timescale 1ns / 1ps
`default_nettype none

package mfbde_pkg;

  // screen geometry and bitmap limit
  localparam int SCREEN_W    = 256;
  localparam int SCREEN_H    = 128;
  localparam int BITMAP_MAX  = 64;
  localparam int STORE_BYTES = (SCREEN_W * SCREEN_H + 7) / 8;

  // pixel linear index width and byte address width
  localparam int LIN_W  = $clog2(SCREEN_W * SCREEN_H);
  localparam int ADDR_W = LIN_W - 3;

  // internal signed coordinate width (holds origin plus size)
  localparam int CW = 14;
  // signed width of y*SCREEN_W+x for byte accesses
  localparam int BLIN_W = 26;
  // width of the bitmap pixel index
  localparam int PIX_W = 6;

  // command codes
  localparam logic [2:0] ACT_CLEAR = 3'd0;
  localparam logic [2:0] ACT_SET   = 3'd1;
  localparam logic [2:0] ACT_WRITE = 3'd2;
  localparam logic [2:0] ACT_FILL  = 3'd3;
  localparam logic [2:0] ACT_LINE  = 3'd4;
  localparam logic [2:0] ACT_BLIT  = 3'd5;
  localparam logic [2:0] ACT_READ  = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_RANGE  = 2'd1;
  localparam logic [1:0] ST_BITMAP = 2'd2;

  // one command word, bitmap excluded
  typedef struct packed {
    logic        [2:0]  action;
    logic signed [11:0] x;
    logic signed [11:0] y;
    logic signed [11:0] end_x;
    logic signed [11:0] end_y;
    logic        [10:0] size_w;
    logic        [10:0] size_h;
    logic        [7:0]  value;
  } cmd_t;

  function automatic logic signed [CW-1:0] smax(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [CW-1:0] smin(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ===== sv/mono_framebuffer_draw_engine.sv =====
// mono_framebuffer_draw_engine.sv: one-bit framebuffer with a pixel-stepping draw sequencer
//
// The engine owns a SCREEN_W x SCREEN_H one-bit framebuffer held in a single-port byte
// memory and runs one command at a time, giving one result word per command. After reset
// a clearing pass writes zero to all STORE_BYTES bytes, one a cycle, and no command is
// taken until it ends; the clear command runs the same sweep. Set pixel, fill, line and
// blit step through their clipped area under one shared counter and coordinate unit:
// every on-screen pixel costs a read and a write of its byte, every off-screen blit pixel
// is skipped without a memory access, plus setup and finish steps. The memory port is the
// limit. A finished result waits in the output register while the next command is taken.
`timescale 1ns / 1ps
`default_nettype none

module mono_framebuffer_draw_engine
  import mfbde_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // command word
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic        [2:0]  action_i,
  input  wire logic signed [11:0] x_i,
  input  wire logic signed [11:0] y_i,
  input  wire logic signed [11:0] end_x_i,
  input  wire logic signed [11:0] end_y_i,
  input  wire logic        [10:0] size_w_i,
  input  wire logic        [10:0] size_h_i,
  input  wire logic        [7:0]  value_i,
  input  wire logic        [63:0] bitmap_bits_i,
  // result word
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic             [7:0]  read_data_o,
  output logic             [1:0]  status_o
);

  // sequencer states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam logic signed [CW-1:0] SW_C = CW'(SCREEN_W);
  localparam logic signed [CW-1:0] SH_C = CW'(SCREEN_H);
  localparam logic signed [CW-1:0] ZERO_C = '0;
  localparam logic signed [CW-1:0] ONE_C = CW'(1);
  localparam logic signed [BLIN_W-1:0] BYTE_END_C = BLIN_W'(STORE_BYTES * 8);
  localparam logic signed [BLIN_W-1:0] BSW_C = BLIN_W'(SCREEN_W);

  logic [2:0] state_q, state_d;
  cmd_t cmd_q, cmd_d;
  logic [63:0] bits_q, bits_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic sweep_cmd_q, sweep_cmd_d;
  logic signed [CW-1:0] xs_q, xs_d, xe_q, xe_d, ys_q, ys_d, ye_q, ye_d;
  logic signed [CW-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [PIX_W-1:0] pix_q, pix_d;
  logic [1:0] stat_q, stat_d;
  logic rd_sel_q, rd_sel_d;
  logic out_valid_q, out_valid_d;
  logic [7:0] read_data_q, read_data_d;
  logic [1:0] status_q, status_d;
  logic [7:0] rdata_q;

  // memory port
  logic mem_we, mem_re;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0] mem_wdata;
  logic [7:0] mem_q [STORE_BYTES];

  // widened command fields
  logic signed [CW-1:0] xw, yw, exw, eyw, ww, hw;
  assign xw  = CW'(cmd_q.x);
  assign yw  = CW'(cmd_q.y);
  assign exw = CW'(cmd_q.end_x);
  assign eyw = CW'(cmd_q.end_y);
  assign ww  = signed'(CW'(cmd_q.size_w));
  assign hw  = signed'(CW'(cmd_q.size_h));

  // byte address for write byte and read byte
  logic signed [BLIN_W-1:0] byte_lin;
  logic byte_ok;
  logic [ADDR_W-1:0] byte_addr;
  assign byte_lin  = BLIN_W'(cmd_q.y) * BSW_C + BLIN_W'(cmd_q.x);
  assign byte_ok   = !byte_lin[BLIN_W-1] && (byte_lin < BYTE_END_C);
  assign byte_addr = byte_lin[ADDR_W+2:3];

  // bitmap area
  logic [21:0] area;
  assign area = 22'(cmd_q.size_w) * 22'(cmd_q.size_h);

  // line and point range terms
  logic x_on, y_on;
  logic signed [CW-1:0] vlo, vhi, hlo, hhi;
  assign x_on = (xw >= ZERO_C) && (xw < SW_C);
  assign y_on = (yw >= ZERO_C) && (yw < SH_C);
  assign vlo  = smax(smin(yw, eyw), ZERO_C);
  assign vhi  = smin(smax(yw, eyw), SH_C - ONE_C);
  assign hlo  = smax(smin(xw, exw), ZERO_C);
  assign hhi  = smin(smax(xw, exw), SW_C - ONE_C);

  // shared pixel stepping unit
  logic signed [CW-1:0] nx, ny;
  logic row_end, last_pix, pix_on;
  logic [LIN_W-1:0] pix_lin;
  logic [7:0] pix_mask;
  assign nx       = cx_q + ONE_C;
  assign ny       = cy_q + ONE_C;
  assign row_end  = nx >= xe_q;
  assign last_pix = row_end && (ny >= ye_q);
  assign pix_on   = (cx_q >= ZERO_C) && (cx_q < SW_C) && (cy_q >= ZERO_C) && (cy_q < SH_C);
  assign pix_lin  = LIN_W'(cy_q) * LIN_W'(SCREEN_W) + LIN_W'(cx_q);
  assign pix_mask = 8'h80 >> pix_lin[2:0];

  // sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    bits_d      = bits_q;
    clr_cnt_d   = clr_cnt_q;
    sweep_cmd_d = sweep_cmd_q;
    xs_d        = xs_q;
    xe_d        = xe_q;
    ys_d        = ys_q;
    ye_d        = ye_q;
    cx_d        = cx_q;
    cy_d        = cy_q;
    pix_d       = pix_q;
    stat_d      = stat_q;
    rd_sel_d    = rd_sel_q;
    out_valid_d = out_valid_q && out_stall_i;
    read_data_d = read_data_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_addr    = pix_lin[LIN_W-1:3];
    mem_wdata   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        clr_cnt_d = clr_cnt_q + ADDR_W'(1);
        if (clr_cnt_q == ADDR_W'(STORE_BYTES - 1)) begin
          clr_cnt_d = '0;
          state_d   = sweep_cmd_q ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = '{action: action_i, x: x_i, y: y_i, end_x: end_x_i, end_y: end_y_i,
                    size_w: size_w_i, size_h: size_h_i, value: value_i};
          bits_d  = bitmap_bits_i;
          state_d = S_SETUP;
        end
      end
      S_SETUP: begin
        stat_d   = ST_OK;
        rd_sel_d = 1'b0;
        pix_d    = '0;
        xs_d     = ZERO_C;
        xe_d     = ZERO_C;
        ys_d     = ZERO_C;
        ye_d     = ZERO_C;
        state_d  = S_RANGE;
        unique case (cmd_q.action)
          ACT_CLEAR: begin
            sweep_cmd_d = 1'b1;
            state_d     = S_CLEAR;
          end
          ACT_SET: begin
            bits_d = {cmd_q.value[0], 63'd0};
            if (x_on && y_on) begin
              xs_d = xw;
              xe_d = xw + ONE_C;
              ys_d = yw;
              ye_d = yw + ONE_C;
            end else begin
              stat_d = ST_RANGE;
            end
          end
          ACT_WRITE: begin
            state_d = S_DONE;
            if (byte_ok) begin
              mem_we    = 1'b1;
              mem_addr  = byte_addr;
              mem_wdata = cmd_q.value;
            end else begin
              stat_d = ST_RANGE;
            end
          end
          ACT_FILL: begin
            bits_d = '1;
            xs_d   = smax(xw, ZERO_C);
            xe_d   = smin(xw + ww, SW_C);
            ys_d   = smax(yw, ZERO_C);
            ye_d   = smin(yw + hw, SH_C);
          end
          ACT_LINE: begin
            bits_d = '1;
            if (xw == exw) begin
              if (x_on) begin
                xs_d = xw;
                xe_d = xw + ONE_C;
                ys_d = vlo;
                ye_d = vhi + ONE_C;
              end
            end else if (y_on) begin
              xs_d = hlo;
              xe_d = hhi + ONE_C;
              ys_d = yw;
              ye_d = yw + ONE_C;
            end
          end
          ACT_BLIT: begin
            if (area > 22'(BITMAP_MAX)) begin
              stat_d  = ST_BITMAP;
              state_d = S_DONE;
            end else begin
              xs_d = xw;
              xe_d = xw + ww;
              ys_d = yw;
              ye_d = yw + hw;
            end
          end
          ACT_READ: begin
            state_d = S_DONE;
            if (byte_ok) begin
              mem_re   = 1'b1;
              mem_addr = byte_addr;
              rd_sel_d = 1'b1;
            end else begin
              stat_d = ST_RANGE;
            end
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_RANGE: begin
        cx_d    = xs_q;
        cy_d    = ys_q;
        state_d = ((xs_q < xe_q) && (ys_q < ye_q)) ? S_CHK : S_DONE;
      end
      S_CHK: begin
        if (pix_on) begin
          mem_re  = 1'b1;
          state_d = S_WR;
        end else begin
          pix_d = pix_q + PIX_W'(1);
          cx_d  = row_end ? xs_q : nx;
          cy_d  = row_end ? ny : cy_q;
          state_d = last_pix ? S_DONE : S_CHK;
        end
      end
      S_WR: begin
        mem_we    = 1'b1;
        mem_wdata = bits_q[~pix_q] ? (rdata_q | pix_mask) : (rdata_q & ~pix_mask);
        pix_d     = pix_q + PIX_W'(1);
        cx_d      = row_end ? xs_q : nx;
        cy_d      = row_end ? ny : cy_q;
        state_d   = last_pix ? S_DONE : S_CHK;
      end
      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          read_data_d = rd_sel_q ? rdata_q : 8'd0;
          status_d    = stat_q;
          sweep_cmd_d = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      sweep_cmd_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      sweep_cmd_q <= sweep_cmd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    bits_q      <= bits_d;
    xs_q        <= xs_d;
    xe_q        <= xe_d;
    ys_q        <= ys_d;
    ye_q        <= ye_d;
    cx_q        <= cx_d;
    cy_q        <= cy_d;
    pix_q       <= pix_d;
    stat_q      <= stat_d;
    rd_sel_q    <= rd_sel_d;
    read_data_q <= read_data_d;
    status_q    <= status_d;
  end

  // framebuffer memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;
  assign status_o    = status_q;

  // a result word only appears at the end of a command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q) == S_DONE)
    else $error("result word without finished command");

  // every pixel write follows its byte read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_WR |-> $past(state_q) == S_CHK && $past(mem_re))
    else $error("pixel write without preceding read");

  // read data is zero unless the status is ok
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> read_data_o == 8'd0)
    else $error("nonzero read data on failed command");

  // status code stays within its defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_RANGE || status_o == ST_BITMAP)
    else $error("undefined status code");

endmodule

`default_nettype wire

// ===== dv/draw_result_checker.sv =====
// draw_result_checker.sv: watches the draw engine channels, predicts each result word and compares
`timescale 1ns / 1ps

module draw_result_checker
  import mfbde_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic        [2:0]  action_i,
  input  logic signed [11:0] x_i,
  input  logic signed [11:0] y_i,
  input  logic signed [11:0] end_x_i,
  input  logic signed [11:0] end_y_i,
  input  logic        [10:0] size_w_i,
  input  logic        [10:0] size_h_i,
  input  logic        [7:0]  value_i,
  input  logic        [63:0] bitmap_bits_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic        [7:0]  read_data_i,
  input  logic        [1:0]  status_i,
  output int                 mismatch_count_o,
  output int                 results_owed_o
);

  typedef struct packed {
    logic [7:0] read_data;
    logic [1:0] status;
  } result_t;

  // shadow copy of the framebuffer and the results still owed by the engine
  logic [7:0] frame_img [STORE_BYTES];
  result_t    owed_results [$];
  result_t    want;
  int         mismatches = 0;

  assign mismatch_count_o = mismatches;

  function automatic bit on_screen(input int px, input int py);
    return px >= 0 && px < SCREEN_W && py >= 0 && py < SCREEN_H;
  endfunction

  // pixel (px,py) sits at bit 7 - lin%8 of byte lin/8
  function automatic void plot(input int px, input int py, input bit on);
    int lin;
    lin = py * SCREEN_W + px;
    frame_img[lin / 8][7 - (lin % 8)] = on;
  endfunction

  // runs one command on the shadow framebuffer and returns its result word
  function automatic result_t apply_draw_cmd(input logic [2:0] act, input int x, input int y,
                                             input int ex, input int ey, input int w,
                                             input int h, input logic [7:0] v,
                                             input logic [63:0] bits);
    result_t r;
    int lin, lo, hi, x0, x1, y0, y1, p;
    r = '0;
    case (act)
      ACT_CLEAR: begin
        foreach (frame_img[k]) frame_img[k] = '0;
      end
      ACT_SET: begin
        if (on_screen(x, y)) plot(x, y, v[0]);
        else r.status = ST_RANGE;
      end
      ACT_WRITE, ACT_READ: begin
        lin = y * SCREEN_W + x;
        if (lin < 0 || lin / 8 >= STORE_BYTES) r.status = ST_RANGE;
        else if (act == ACT_WRITE) frame_img[lin / 8] = v;
        else r.read_data = frame_img[lin / 8];
      end
      ACT_FILL: begin
        x0 = (x > 0) ? x : 0;
        y0 = (y > 0) ? y : 0;
        x1 = (x + w < SCREEN_W) ? x + w : SCREEN_W;
        y1 = (y + h < SCREEN_H) ? y + h : SCREEN_H;
        for (int j = y0; j < y1; j++)
          for (int i = x0; i < x1; i++) plot(i, j, 1'b1);
      end
      ACT_LINE: begin
        // vertical when both ends share a column, clipped on both axes
        if (x == ex) begin
          lo = (y < ey) ? y : ey;
          hi = (y > ey) ? y : ey;
          if (lo < 0) lo = 0;
          if (hi > SCREEN_H - 1) hi = SCREEN_H - 1;
          if (x >= 0 && x < SCREEN_W)
            for (int j = lo; j <= hi; j++) plot(x, j, 1'b1);
        end else begin
          lo = (x < ex) ? x : ex;
          hi = (x > ex) ? x : ex;
          if (lo < 0) lo = 0;
          if (hi > SCREEN_W - 1) hi = SCREEN_W - 1;
          if (y >= 0 && y < SCREEN_H)
            for (int i = lo; i <= hi; i++) plot(i, y, 1'b1);
        end
      end
      ACT_BLIT: begin
        if (w * h > BITMAP_MAX) begin
          r.status = ST_BITMAP;
        end else begin
          // row-major bitmap, zeros written as well as ones
          for (int j = 0; j < h; j++)
            for (int i = 0; i < w; i++) begin
              p = j * w + i;
              if (on_screen(x + i, y + j)) plot(x + i, y + j, bits[63 - p]);
            end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // compare results, then predict the newly accepted command
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owed_results.delete();
      foreach (frame_img[k]) frame_img[k] = '0;
      results_owed_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result word with none expected: read_data %0h status %0d",
                   $time, read_data_i, status_i);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (read_data_i !== want.read_data) begin
            $display("%0t: read_data expected %0h actual %0h",
                     $time, want.read_data, read_data_i);
            mismatches++;
          end
          if (status_i !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status_i);
            mismatches++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        owed_results.push_back(apply_draw_cmd(action_i, x_i, y_i, end_x_i, end_y_i,
                                              size_w_i, size_h_i, value_i, bitmap_bits_i));
      results_owed_o <= owed_results.size();
    end
  end

endmodule

// ===== dv/testbench.sv =====
// testbench.sv: stimulus, clock, reset and verdict for the framebuffer draw engine
`timescale 1ns / 1ps

module testbench;
  import mfbde_pkg::*;

  // watchdog covers a full-screen fill several times over
  localparam int QUIET_LIMIT    = 300000;
  localparam int WORDS_PER_PASS = 134;
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic        [2:0]  action = ACT_CLEAR;
  logic signed [11:0] x = '0;
  logic signed [11:0] y = '0;
  logic signed [11:0] end_x = '0;
  logic signed [11:0] end_y = '0;
  logic        [10:0] size_w = '0;
  logic        [10:0] size_h = '0;
  logic        [7:0]  value = '0;
  logic        [63:0] bitmap_bits = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic        [7:0]  read_data;
  logic        [1:0]  status;

  int idle_pct = 21;
  int stall_pct = 60;
  int quiet_cycles = 0;
  int mismatch_count;
  int results_owed;

  mono_framebuffer_draw_engine DUT (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .action_i(action), .x_i(x), .y_i(y), .end_x_i(end_x), .end_y_i(end_y),
    .size_w_i(size_w), .size_h_i(size_h), .value_i(value), .bitmap_bits_i(bitmap_bits),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .read_data_o(read_data), .status_o(status)
  );

  draw_result_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .action_i(action), .x_i(x), .y_i(y), .end_x_i(end_x), .end_y_i(end_y),
    .size_w_i(size_w), .size_h_i(size_h), .value_i(value), .bitmap_bits_i(bitmap_bits),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .read_data_i(read_data), .status_i(status),
    .mismatch_count_o(mismatch_count), .results_owed_o(results_owed)
  );

  // 8 ns clock
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(0, 99) < stall_pct);

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("mono_framebuffer_draw_engine: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // offer one command word, with random idle cycles ahead of it
  task automatic send_cmd(input logic [2:0] act, input int cx, input int cy, input int cex,
                          input int cey, input int cw, input int ch, input logic [7:0] v,
                          input logic [63:0] bits);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    action      <= act;
    x           <= cx[11:0];
    y           <= cy[11:0];
    end_x       <= cex[11:0];
    end_y       <= cey[11:0];
    size_w      <= cw[10:0];
    size_h      <= ch[10:0];
    value       <= v;
    bitmap_bits <= bits;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every owed result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  function automatic int full_coord();
    return int'($urandom_range(0, 4095)) - 2048;
  endfunction

  // mostly just around the screen, now and then anywhere in the 12-bit range
  function automatic int near_coord(input int lim);
    if ($urandom_range(0, 9) == 0) return full_coord();
    return int'($urandom_range(0, lim + 8)) - 4;
  endfunction

  task automatic random_cmd();
    int pick, cx, cy, cex, cey, cw, ch;
    logic [2:0]  act;
    logic [7:0]  v;
    logic [63:0] bits;
    pick = $urandom_range(0, 99);
    cx   = near_coord(SCREEN_W);
    cy   = near_coord(SCREEN_H);
    cex  = near_coord(SCREEN_W);
    cey  = near_coord(SCREEN_H);
    cw   = $urandom_range(0, 12);
    ch   = $urandom_range(0, 12);
    v    = 8'($urandom);
    bits = {$urandom, $urandom};
    if (pick < 2) begin
      act = ACT_CLEAR;
    end else if (pick < 17) begin
      act = ACT_SET;
    end else if (pick < 32) begin
      act = ACT_WRITE;
    end else if (pick < 50) begin
      act = ACT_READ;
    end else if (pick < 64) begin
      act = ACT_FILL;
      // huge sizes only near the bottom edge so the clipped area stays a few rows
      if ($urandom_range(0, 9) == 0) begin
        cw = $urandom_range(0, 2047);
        ch = $urandom_range(0, 2047);
        cy = $urandom_range(SCREEN_H - 6, SCREEN_H + 8);
      end
    end else if (pick < 80) begin
      act = ACT_LINE;
      if ($urandom_range(0, 2) == 0) cex = cx;
    end else if (pick < 94) begin
      act = ACT_BLIT;
      cw  = $urandom_range(0, 10);
      ch  = $urandom_range(0, 10);
      if ($urandom_range(0, 7) == 0) begin
        cw = $urandom_range(0, 2047);
        ch = $urandom_range(0, 2047);
      end
    end else if (pick < 97) begin
      act = ACT_UNUSED;
    end else begin
      // noise: cheap commands with fields anywhere in range
      case ($urandom_range(0, 3))
        0:       act = ACT_SET;
        1:       act = ACT_WRITE;
        2:       act = ACT_READ;
        default: act = ACT_BLIT;
      endcase
      cx  = full_coord();
      cy  = full_coord();
      cex = full_coord();
      cey = full_coord();
      cw  = $urandom_range(0, 2047);
      ch  = $urandom_range(0, 2047);
    end
    send_cmd(act, cx, cy, cex, cey, cw, ch, v, bits);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed: edges of the screen and store, each command and its corner cases
    send_cmd(ACT_READ,    0,     0,     0,   0,    0,    0,    8'h00, '0);
    send_cmd(ACT_SET,     0,     0,     0,   0,    0,    0,    8'hFE, '0);
    send_cmd(ACT_SET,     0,     0,     0,   0,    0,    0,    8'h01, '0);
    send_cmd(ACT_SET,     255,   127,   0,   0,    0,    0,    8'hFF, '1);
    send_cmd(ACT_SET,     -1,    0,     0,   0,    0,    0,    8'h01, '0);
    send_cmd(ACT_SET,     256,   128,   0,   0,    0,    0,    8'h01, '0);
    send_cmd(ACT_SET,     2047,  -2048, 0,   0,    0,    0,    8'h01, '0);
    send_cmd(ACT_WRITE,   2047,  0,     0,   0,    0,    0,    8'hA5, '0);
    send_cmd(ACT_WRITE,   -8,    1,     0,   0,    0,    0,    8'h3C, '0);
    send_cmd(ACT_WRITE,   2047,  127,   0,   0,    0,    0,    8'hFF, '0);
    send_cmd(ACT_WRITE,   -1,    0,     0,   0,    0,    0,    8'hFF, '0);
    send_cmd(ACT_READ,    2047,  0,     0,   0,    0,    0,    8'h00, '0);
    send_cmd(ACT_READ,    255,   127,   0,   0,    0,    0,    8'h00, '0);
    send_cmd(ACT_FILL,    -2048, -2048, 0,   0,    2047, 2047, 8'h00, '0);
    send_cmd(ACT_FILL,    250,   124,   0,   0,    20,   10,   8'h00, '0);
    send_cmd(ACT_LINE,    300,   2,     -5,  0,    0,    0,    8'h00, '0);
    send_cmd(ACT_LINE,    5,     200,   5,   -3,   0,    0,    8'h00, '0);
    send_cmd(ACT_LINE,    -1,    0,     -1,  50,   0,    0,    8'h00, '0);
    send_cmd(ACT_LINE,    0,     -1,    30,  2047, 0,    0,    8'h00, '0);
    send_cmd(ACT_BLIT,    252,   124,   0,   0,    8,    8,    8'h00, 64'hF00F_A55A_0FF0_C33C);
    send_cmd(ACT_BLIT,    0,     0,     0,   0,    9,    8,    8'h00, '1);
    send_cmd(ACT_BLIT,    0,     0,     0,   0,    0,    2047, 8'h00, '1);
    send_cmd(ACT_BLIT,    0,     0,     0,   0,    2047, 2047, 8'h00, '1);
    send_cmd(ACT_UNUSED,  0,     0,     0,   0,    0,    0,    8'hFF, '1);
    send_cmd(ACT_FILL,    0,     0,     0,   0,    2047, 2047, 8'h00, '0);
    send_cmd(ACT_READ,    64,    64,    0,   0,    0,    0,    8'h00, '0);
    send_cmd(ACT_CLEAR,   0,     0,     0,   0,    0,    0,    8'h00, '0);

    // random: sender idles then receiver stalls, swapped, then full rate
    for (int pass = 0; pass < 3; pass++) begin
      idle_pct  = (pass == 0) ? 21 : (pass == 1) ? 60 : 0;
      stall_pct = (pass == 0) ? 60 : (pass == 1) ? 21 : 0;
      for (int n = 0; n < WORDS_PER_PASS; n++) begin
        random_cmd();
        if (n == WORDS_PER_PASS / 2) drain_results();
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mono_framebuffer_draw_engine: match");
    end else begin
      $display("mono_framebuffer_draw_engine: mismatch");
    end
    $finish;
  end

endmodule
